@@ sv/chd_pkg.sv @@
package chd_pkg;

  localparam int CODE_LEN_W = 5;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_DECODE  = 2'd2,
    CMD_RESTART = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_INVALID  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    command_t              command;
    logic [7:0]            symbol;
    logic [CODE_LEN_W-1:0] code_len;
    logic [7:0]            data_byte;
    logic [3:0]            bit_count;
  } item_t;

  typedef struct packed {
    logic [7:0] symbol_out;
    status_t    status;
    logic       last;
  } result_t;

endpackage

@@ sv/chd_ram.sv @@
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/canonical_huffman_decoder.sv @@
// Canonical Huffman decoder. A clear beat empties the table; add beats load one symbol each,
// in code order with non-decreasing lengths, and grow the code one bit at a time up to the
// new length; a rejected add gives one result with status 2. A decode beat feeds bit_count
// bits (saturated to 8) of data_byte, MSB first, one bit per cycle while the result side does
// not stall, against the per-length first code, count and base registers; each completed
// code reads the symbol store (one RAM port) and yields one result, the last result of a
// beat is marked, and a code reaching MAX_CODE_LEN bits without a match gives status 1.
// Restart drops the partial code. The input is stalled while a beat is in work.
module canonical_huffman_decoder #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  chd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output chd_pkg::result_t result
);

  import chd_pkg::*;

  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_W  = (LEN_W > CODE_LEN_W) ? LEN_W : CODE_LEN_W;
  localparam int TAB_W  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CNT_W  = $clog2(SYMBOL_COUNT + 1);
  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int CODE_W = MAX_CODE_LEN;
  localparam int DIFF_W = (CODE_W > CNT_W) ? CODE_W : CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_BITS, S_FLUSH} state_t;

  state_t             state;
  logic [CODE_W-1:0]  first_code   [MAX_CODE_LEN];
  logic [CNT_W-1:0]   length_count [MAX_CODE_LEN];
  logic [ADDR_W-1:0]  base_index   [MAX_CODE_LEN];
  logic [CODE_W:0]    next_code;
  logic [CODE_W:0]    len_mark;
  logic [LEN_W-1:0]   previous_length;
  logic [LEN_W-1:0]   add_length;
  logic [7:0]         add_symbol;
  logic [CNT_W-1:0]   symbols_loaded;
  logic [CODE_W-1:0]  partial_code;
  logic [LEN_W-1:0]   partial_length;
  logic [7:0]         bit_shift;
  logic [3:0]         bits_left;
  logic               pend_valid;
  status_t            pend_status;
  logic               pend_from_ram;

  logic [CMP_W-1:0]   len_ext;
  logic               add_ok;
  logic               bit_in;
  logic [CODE_W-1:0]  code_next;
  logic [LEN_W-1:0]   len_next;
  logic [TAB_W-1:0]   tab_sel;
  logic [TAB_W-1:0]   tab_add;
  logic [CODE_W-1:0]  code_diff;
  logic               hit;
  logic               too_long;
  logic               produce;
  logic               result_free;
  logic               step_go;
  logic               out_load;
  logic [ADDR_W-1:0]  lookup_addr;
  logic               ram_we;
  logic               ram_re;
  logic [7:0]         ram_rdata;
  logic [7:0]         pend_symbol;

  // code space is used up once next_code reaches 1 << previous_length
  assign len_ext = CMP_W'(item.code_len);
  assign add_ok  = (len_ext != '0) && (len_ext <= CMP_W'(MAX_CODE_LEN))
                   && (len_ext >= CMP_W'(previous_length))
                   && (symbols_loaded < CNT_W'(SYMBOL_COUNT))
                   && (next_code != len_mark);

  assign bit_in      = bit_shift[7];
  assign code_next   = CODE_W'({partial_code, bit_in});
  assign len_next    = partial_length + LEN_W'(1);
  assign tab_sel     = TAB_W'(partial_length);
  assign tab_add     = TAB_W'(add_length - LEN_W'(1));
  assign code_diff   = code_next - first_code[tab_sel];
  assign hit         = (length_count[tab_sel] != '0)
                       && (code_next >= first_code[tab_sel])
                       && (DIFF_W'(code_diff) < DIFF_W'(length_count[tab_sel]));
  assign too_long    = (len_next == LEN_W'(MAX_CODE_LEN));
  assign produce     = hit || too_long;
  assign result_free = !result_valid || !result_stall;
  assign step_go     = !produce || !pend_valid || result_free;
  assign out_load    = ((state == S_BITS) && step_go && produce && pend_valid)
                       || ((state == S_FLUSH) && pend_valid && result_free);
  assign lookup_addr = base_index[tab_sel] + ADDR_W'(code_diff);
  assign pend_symbol = pend_from_ram ? ram_rdata : 8'd0;

  assign ram_we     = (state == S_ALIGN) && (previous_length == add_length);
  assign ram_re     = (state == S_BITS) && step_go && hit;
  assign item_stall = (state != S_IDLE);

  chd_ram #(
    .WIDTH(8),
    .DEPTH(SYMBOL_COUNT)
  ) u_symbol_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(symbols_loaded[ADDR_W-1:0]),
    .wdata(add_symbol),
    .re   (ram_re),
    .raddr(lookup_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      next_code       <= '0;
      len_mark        <= (CODE_W + 1)'(2);
      previous_length <= LEN_W'(1);
      symbols_loaded  <= '0;
      partial_code    <= '0;
      partial_length  <= '0;
      pend_valid      <= 1'b0;
      result_valid    <= 1'b0;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        length_count[i] <= '0;
      end
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (item.command)
              CMD_CLEAR: begin
                next_code       <= '0;
                len_mark        <= (CODE_W + 1)'(2);
                previous_length <= LEN_W'(1);
                symbols_loaded  <= '0;
                partial_code    <= '0;
                partial_length  <= '0;
                for (int i = 0; i < MAX_CODE_LEN; i++) begin
                  length_count[i] <= '0;
                end
              end
              CMD_RESTART: begin
                partial_code   <= '0;
                partial_length <= '0;
              end
              CMD_ADD: begin
                if (add_ok) begin
                  add_length <= LEN_W'(len_ext);
                  add_symbol <= item.symbol;
                  state      <= S_ALIGN;
                end else begin
                  pend_valid    <= 1'b1;
                  pend_status   <= ST_REJECTED;
                  pend_from_ram <= 1'b0;
                  state         <= S_FLUSH;
                end
              end
              CMD_DECODE: begin
                if (item.bit_count != 4'd0) begin
                  bit_shift <= item.data_byte;
                  bits_left <= (item.bit_count > 4'd8) ? 4'd8 : item.bit_count;
                  state     <= S_BITS;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ALIGN: begin
          if (previous_length == add_length) begin
            if (length_count[tab_add] == '0) begin
              first_code[tab_add] <= next_code[CODE_W-1:0];
              base_index[tab_add] <= symbols_loaded[ADDR_W-1:0];
            end
            length_count[tab_add] <= length_count[tab_add] + CNT_W'(1);
            symbols_loaded        <= symbols_loaded + CNT_W'(1);
            next_code             <= next_code + (CODE_W + 1)'(1);
            state                 <= S_IDLE;
          end else begin
            // grow the code one bit per cycle up to the new length
            next_code       <= next_code << 1;
            len_mark        <= len_mark << 1;
            previous_length <= previous_length + LEN_W'(1);
          end
        end
        S_BITS: begin
          if (step_go) begin
            if (produce) begin
              if (pend_valid) begin
                result <= '{symbol_out: pend_symbol, status: pend_status, last: 1'b0};
              end
              pend_valid     <= 1'b1;
              pend_status    <= hit ? ST_SYMBOL : ST_INVALID;
              pend_from_ram  <= hit;
              partial_code   <= '0;
              partial_length <= '0;
            end else begin
              partial_code   <= code_next;
              partial_length <= len_next;
            end
            bit_shift <= bit_shift << 1;
            bits_left <= bits_left - 4'd1;
            if (bits_left == 4'd1) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // the held result is the last of this beat
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (result_free) begin
            result     <= '{symbol_out: pend_symbol, status: pend_status, last: 1'b1};
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/chd_checker.sv @@
module chd_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input chd_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input chd_pkg::result_t result
);

  import chd_pkg::*;

  // hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.command == CMD_CLEAR |=> !item_stall)
    else $error("clear beat kept the input stalled");

  a_error_no_symbol: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_SYMBOL |-> result.symbol_out == 8'd0)
    else $error("error result carries a symbol");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_REJECTED |-> result.last)
    else $error("rejected entry result not marked last");

endmodule

bind canonical_huffman_decoder chd_checker u_chd_checker (.*);

@@ tb/tb_top.sv @@
import chd_pkg::*;

class huff_scoreboard;
  localparam int MAX_LEN = 16;
  localparam int STORE_DEPTH = 256;

  logic [7:0]  sym_store [STORE_DEPTH];
  logic [15:0] first_code [MAX_LEN+1];
  logic [8:0]  len_count [MAX_LEN+1];
  logic [7:0]  base_idx [MAX_LEN+1];
  logic [16:0] next_code;
  logic [4:0]  prev_len;
  logic [8:0]  loaded;
  logic [15:0] partial;
  logic [4:0]  partial_len;

  result_t expected_q [$];
  int errors, n_beats, n_symbols, n_invalid, n_rejected;

  function new();
    clear_table();
  endfunction

  function void clear_table();
    for (int i = 0; i <= MAX_LEN; i++) begin
      first_code[i] = '0;
      len_count[i]  = '0;
      base_idx[i]   = '0;
    end
    next_code   = '0;
    prev_len    = 5'd1;
    loaded      = '0;
    partial     = '0;
    partial_len = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // work out the results that one accepted input beat causes
  function void note_item(item_t it);
    int len, cnt, pc, off, idx;
    longint code;
    bit ok, have;
    result_t hold, r;
    n_beats++;
    have = 1'b0;
    case (it.command)
      CMD_CLEAR: clear_table();
      CMD_RESTART: begin
        partial     = '0;
        partial_len = '0;
      end
      CMD_ADD: begin
        len  = it.code_len;
        code = 0;
        ok = len >= 1 && len <= MAX_LEN && len >= prev_len && loaded < STORE_DEPTH;
        if (ok) begin
          code = longint'(next_code) << (len - prev_len);
          ok = code < (longint'(1) << len);
        end
        if (!ok) begin
          r.symbol_out = '0;
          r.status     = ST_REJECTED;
          r.last       = 1'b1;
          expected_q.push_back(r);
        end else begin
          if (len_count[len] == 0) begin
            first_code[len] = code[15:0];
            base_idx[len]   = loaded[7:0];
          end
          len_count[len]++;
          sym_store[loaded[7:0]] = it.symbol;
          loaded++;
          next_code = 17'(code + 1);
          prev_len  = 5'(len);
        end
      end
      default: begin
        cnt = (it.bit_count > 8) ? 8 : it.bit_count;
        for (int i = 0; i < cnt; i++) begin
          partial = {partial[14:0], it.data_byte[7-i]};
          partial_len++;
          len = partial_len;
          pc  = partial;
          off = pc - int'(first_code[len]);
          r.last = 1'b0;
          if (len_count[len] != 0 && pc >= int'(first_code[len]) && off < int'(len_count[len]))
          begin
            idx = int'(base_idx[len]) + off;
            r.symbol_out = (idx < STORE_DEPTH) ? sym_store[idx] : 8'd0;
            r.status     = ST_SYMBOL;
          end else if (len >= MAX_LEN) begin
            r.symbol_out = '0;
            r.status     = ST_INVALID;
          end else begin
            continue;
          end
          partial     = '0;
          partial_len = '0;
          // hold back the newest result until we know whether it ends the beat
          if (have) expected_q.push_back(hold);
          hold = r;
          have = 1'b1;
        end
        if (have) begin
          hold.last = 1'b1;
          expected_q.push_back(hold);
        end
      end
    endcase
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result symbol_out=%0h status=%0d last=%0b",
               $time, got.symbol_out, got.status, got.last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    case (want.status)
      ST_SYMBOL:  n_symbols++;
      ST_INVALID: n_invalid++;
      default:    n_rejected++;
    endcase
    if (got.symbol_out !== want.symbol_out) begin
      $display("%0t: symbol_out expected %0h actual %0h", $time, want.symbol_out, got.symbol_out);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  bit steady_flow = 1'b0;
  int table_codes [$];
  int table_lens [$];
  huff_scoreboard sb = new();

  canonical_huffman_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= !steady_flow && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic item_t mk_item(command_t c);
    item_t it;
    it.command   = c;
    it.symbol    = 8'($urandom);
    it.code_len  = CODE_LEN_W'($urandom);
    it.data_byte = 8'($urandom);
    it.bit_count = 4'($urandom);
    return it;
  endfunction

  function automatic item_t mk_add(int sym, int len);
    item_t it;
    it = mk_item(CMD_ADD);
    it.symbol   = 8'(sym);
    it.code_len = CODE_LEN_W'(len);
    return it;
  endfunction

  function automatic item_t mk_dec(int data, int cnt);
    item_t it;
    it = mk_item(CMD_DECODE);
    it.data_byte = 8'(data);
    it.bit_count = 4'(cnt);
    return it;
  endfunction

  task automatic send(input item_t it);
    while (!steady_flow && $urandom_range(0, 99) < 30) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  // remember the code of every entry the table takes, for building bit streams
  task automatic add_symbol(input int sym, input int len);
    int count_was;
    count_was = sb.loaded;
    send(mk_add(sym, len));
    if (sb.loaded != count_was) begin
      table_codes.push_back(int'(sb.next_code) - 1);
      table_lens.push_back(int'(sb.prev_len));
    end
  endtask

  task automatic random_table();
    int n_syms, len, prev;
    table_codes.delete();
    table_lens.delete();
    send(mk_item(CMD_CLEAR));
    n_syms = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 20);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    for (int k = 0; k < n_syms; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_symbol($urandom_range(0, 255), $urandom_range(0, 31));
      end else begin
        prev = sb.prev_len;
        if (len < prev) len = prev;
        if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 2);
        if (len > 16) len = 16;
        // grow the length until the next code fits
        while (len < 16 && (longint'(sb.next_code) << (len - prev)) >= (longint'(1) << len))
          len++;
        add_symbol($urandom_range(0, 255), len);
      end
    end
  endtask

  task automatic decode_stream(input int n_codes);
    bit bits [$];
    int pick, cnt, r;
    logic [7:0] data;
    for (int k = 0; k < n_codes; k++) begin
      if (table_codes.size() == 0 || $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) bits.push_back(1'($urandom));
      end else begin
        pick = $urandom_range(0, table_codes.size() - 1);
        for (int b = table_lens[pick] - 1; b >= 0; b--) bits.push_back(table_codes[pick][b]);
      end
    end
    while (bits.size() > 0) begin
      if ($urandom_range(0, 19) == 0) add_symbol($urandom_range(0, 255), $urandom_range(0, 31));
      r = $urandom_range(0, 19);
      cnt = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      data = 8'($urandom);
      for (int b = 0; b < cnt && b < 8 && bits.size() > 0; b++) data[7-b] = bits.pop_front();
      send(mk_dec(data, cnt));
    end
    if ($urandom_range(0, 2) == 0) send(mk_item(CMD_RESTART));
  endtask

  initial begin
    int round;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: sixteen bits without a match give an invalid code
    send(mk_dec(8'hA5, 8));
    send(mk_dec(8'h3C, 0));
    send(mk_dec(8'h3C, 8));
    send(mk_item(CMD_CLEAR));
    // codes 00, 01, 100, 1010, then 1011 followed by twelve zeros
    send(mk_add(8'h00, 2));
    send(mk_add(8'hFF, 2));
    send(mk_add(8'h5A, 3));
    send(mk_add(8'hA5, 4));
    send(mk_add(8'h81, 16));
    send(mk_add(8'h11, 1));
    send(mk_add(8'h22, 0));
    send(mk_add(8'h33, 31));
    send(mk_dec(8'b0001_1001, 8));
    send(mk_dec(8'b0100_0000, 3));
    send(mk_dec(8'h00, 15));
    // add in the middle of a code; the partial code must survive it
    send(mk_dec(8'hB0, 4));
    send(mk_add(8'h3C, 16));
    send(mk_dec(8'h00, 8));
    send(mk_dec(8'h10, 4));
    send(mk_dec(8'hFF, 8));
    send(mk_dec(8'hFF, 8));
    send(mk_dec(8'hB0, 4));
    send(mk_item(CMD_RESTART));
    send(mk_dec(8'h00, 2));
    // code space overflow at length one
    send(mk_item(CMD_CLEAR));
    send(mk_add(8'h01, 1));
    send(mk_add(8'h02, 1));
    send(mk_add(8'h03, 1));
    send(mk_dec(8'h40, 2));

    round = 0;
    while (sb.n_beats < 160) begin
      steady_flow = (round == 1);
      random_table();
      decode_stream($urandom_range(8, 30));
      round++;
    end
    steady_flow = 1'b0;
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d input beats over %0d random tables and the directed cases",
             sb.n_beats, round);
    $display("checked %0d symbols, %0d invalid codes, %0d rejected entries", sb.n_symbols,
             sb.n_invalid, sb.n_rejected);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
